// ===== sv/afl_pkg.sv =====
// Package for the audio sample FIFO with low-watermark refill request.
// Holds the command and register index codes, the item and result types and defaults.
// Used by every module of the block; depends on nothing.
package afl_pkg;

	localparam int AFL_DEPTH     = 4096;
	localparam int AFL_MAX_CHUNK = 512;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME       = 2'd2;

	localparam logic [9:0]  CHUNK_FRAMES_RST = 10'd512;
	localparam logic [11:0] LOW_WATER_RST    = 12'd2048;
	localparam logic [15:0] VOLUME_RST       = 16'd32768;
	localparam logic [15:0] UNITY_GAIN       = 16'd32768;
	localparam logic [11:0] COUNT_MAX        = 12'd4095;

	localparam logic signed [15:0] MOST_NEG  = 16'sh8000;
	localparam logic signed [15:0] NEG_FULL  = 16'sh8001;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_PULL  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} afl_cmd_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic signed [15:0]  sample_in;
		logic                batch_last;
	} afl_item_t;

	typedef struct packed {
		logic                accepted;
		logic [11:0]         written_count;
		logic                out_valid;
		logic signed [15:0]  sample_out;
		logic                chunk_last;
		logic                needs_data;
		logic [11:0]         level;
	} afl_result_t;

	// Status of one item after the FIFO update, before volume scaling.
	typedef struct packed {
		logic        valid;
		logic        accepted;
		logic [11:0] written_count;
		logic        out_valid;
		logic        chunk_last;
		logic        needs_data;
		logic [11:0] level;
	} afl_stage_t;

endpackage

// ===== sv/afl_core.sv =====
// FIFO control and sample memory of the audio FIFO: pointers, chunk and batch counters.
// Registers the status of each item and the sample read for a pull.
// Depends on afl_pkg.
module afl_core
	import afl_pkg::*;
#(
	parameter int DEPTH     = AFL_DEPTH,
	parameter int MAX_CHUNK = AFL_MAX_CHUNK
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  afl_item_t          item,
	input  logic [9:0]         chunk_frames,
	input  logic [11:0]        low_water,
	output afl_stage_t         stage_s1,
	output logic signed [15:0] rd_data_s1
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(MAX_CHUNK + 1);
	localparam int VW0 = (AW > CW) ? AW : CW;
	localparam int VW  = (VW0 > 12) ? VW0 : 12;

	logic [15:0]   mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q, wp_n, rp_n;
	logic          refill_q, refill_n;
	logic [CW-1:0] chunk_left_q, chunk_left_n;
	logic [11:0]   batch_q, batch_n, report_count;

	logic [AW-1:0]      level, level_n, level_pop;
	logic [VW-1:0]      need_w;
	logic               full, do_write, do_pop, chunk_end;
	logic signed [15:0] clamped;
	logic [AW+11:0]     level_wide;

	always_comb begin
		if (wp_q >= rp_q) begin
			level = wp_q - rp_q;
		end else begin
			level = AW'((AW+1)'(wp_q) + (AW+1)'(DEPTH) - (AW+1)'(rp_q));
		end
		full = (level == AW'(DEPTH - 1));
		level_pop = level - AW'(1);

		need_w = VW'(chunk_frames);
		if (need_w == '0) begin
			need_w = VW'(1);
		end
		if (need_w > VW'(MAX_CHUNK)) begin
			need_w = VW'(MAX_CHUNK);
		end

		clamped = (item.sample_in == MOST_NEG) ? NEG_FULL : item.sample_in;

		wp_n         = wp_q;
		rp_n         = rp_q;
		refill_n     = refill_q;
		chunk_left_n = chunk_left_q;
		batch_n      = batch_q;
		do_write     = 1'b0;
		do_pop       = 1'b0;
		chunk_end    = 1'b0;

		case (item.cmd)
			CMD_WRITE: begin
				if (!full) begin
					do_write = 1'b1;
					wp_n = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
					if (batch_q != COUNT_MAX) begin
						batch_n = batch_q + 12'd1;
					end
				end
			end
			CMD_PULL: begin
				if (chunk_left_q == '0) begin
					if (VW'(level) >= need_w) begin
						chunk_left_n = CW'(need_w);
					end else begin
						refill_n = 1'b1;
					end
				end
				if (chunk_left_n != '0 && level != '0) begin
					do_pop = 1'b1;
					rp_n = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
					chunk_left_n = chunk_left_n - CW'(1);
					if (chunk_left_n == '0) begin
						chunk_end = 1'b1;
						if (VW'(level_pop) < VW'(low_water)) begin
							refill_n = 1'b1;
						end
					end
				end
			end
			CMD_CLEAR: begin
				refill_n = 1'b0;
			end
			default: begin
			end
		endcase

		report_count = batch_n;
		if (item.cmd == CMD_WRITE && item.batch_last) begin
			batch_n = '0;
		end

		if (wp_n >= rp_n) begin
			level_n = wp_n - rp_n;
		end else begin
			level_n = AW'((AW+1)'(wp_n) + (AW+1)'(DEPTH) - (AW+1)'(rp_n));
		end
		level_wide = (AW+12)'(level_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			rp_q         <= '0;
			refill_q     <= 1'b1;
			chunk_left_q <= '0;
			batch_q      <= '0;
			stage_s1     <= '0;
		end else begin
			stage_s1.valid <= accept;
			if (accept) begin
				wp_q                   <= wp_n;
				rp_q                   <= rp_n;
				refill_q               <= refill_n;
				chunk_left_q           <= chunk_left_n;
				batch_q                <= batch_n;
				stage_s1.accepted      <= do_write;
				stage_s1.written_count <= report_count;
				stage_s1.out_valid     <= do_pop;
				stage_s1.chunk_last    <= chunk_end;
				stage_s1.needs_data    <= refill_n;
				stage_s1.level         <= level_wide[11:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_write) begin
			mem[wp_q] <= clamped;
		end
		if (accept) begin
			rd_data_s1 <= mem[rp_q];
		end
	end

endmodule

// ===== sv/afl_scale.sv =====
// Volume stage of the audio FIFO: scales a pulled sample by the gain and registers the result.
// Depends on afl_pkg.
module afl_scale
	import afl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  afl_stage_t         stage_s1,
	input  logic signed [15:0] rd_data_s1,
	input  logic [15:0]        volume,
	output logic               done,
	output afl_result_t        result
);

	logic [15:0]        gain;
	logic signed [32:0] product;

	always_comb begin
		gain    = (volume > UNITY_GAIN) ? UNITY_GAIN : volume;
		product = 33'(rd_data_s1) * $signed({1'b0, gain});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_s1.valid) begin
			result.accepted      <= stage_s1.accepted;
			result.written_count <= stage_s1.written_count;
			result.out_valid     <= stage_s1.out_valid;
			result.sample_out    <= stage_s1.out_valid ? product[30:15] : '0;
			result.chunk_last    <= stage_s1.chunk_last;
			result.needs_data    <= stage_s1.needs_data;
			result.level         <= stage_s1.level;
		end
	end

endmodule

// ===== sv/audio_fifo_low_watermark.sv =====
// Top level of the audio sample FIFO with low-watermark refill request.
// Holds the configuration registers; depends on afl_pkg, afl_core and afl_scale.
//
// Usage: an item (cmd, sample_in, batch_last) is transferred at a rising edge with start
// high and busy low. busy is always low, so one item may be transferred in every cycle.
// Each item gives exactly one result, shown on result for one cycle with done high;
// its status is registered in afl_core, then the result and done in afl_scale.
// Results come in transfer order. The receiver cannot stall, so nothing waits on it.
// Throughput is one item per clock; the FIFO update and the sample memory read are
// registered in afl_core, and the volume multiply after them in afl_scale.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while no item is in
// flight; index 0 is chunk_frames, 1 is low_water, 2 is volume.
// After reset the FIFO is empty, the refill request is raised, the batch count and chunk
// are cleared and the registers hold 512, 2048 and unity gain. The sample memory is not
// cleared; only entries that were written are ever output.
module audio_fifo_low_watermark
	import afl_pkg::*;
#(
	parameter int DEPTH     = AFL_DEPTH,
	parameter int MAX_CHUNK = AFL_MAX_CHUNK
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  afl_item_t             item,
	output logic                  done,
	output afl_result_t           result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [9:0]         chunk_frames_q;
	logic [11:0]        low_water_q;
	logic [15:0]        volume_q;
	logic               accept;
	afl_stage_t         stage_s1;
	logic signed [15:0] rd_data_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_frames_q <= CHUNK_FRAMES_RST;
			low_water_q    <= LOW_WATER_RST;
			volume_q       <= VOLUME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHUNK_FRAMES: chunk_frames_q <= cfg_wdata[9:0];
				CFG_LOW_WATER:    low_water_q    <= cfg_wdata[11:0];
				CFG_VOLUME:       volume_q       <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	afl_core #(
		.DEPTH     (DEPTH),
		.MAX_CHUNK (MAX_CHUNK)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.chunk_frames (chunk_frames_q),
		.low_water    (low_water_q),
		.stage_s1     (stage_s1),
		.rd_data_s1   (rd_data_s1)
	);

	afl_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage_s1   (stage_s1),
		.rd_data_s1 (rd_data_s1),
		.volume     (volume_q),
		.done       (done),
		.result     (result)
	);

endmodule

// ===== sv/afl_checker.sv =====
// Port-level checks for the audio FIFO top level, attached by the bind at the end.
// Depends on afl_pkg and audio_fifo_low_watermark.
module afl_checker
	import afl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input afl_result_t result
);

	// Every transfer produces its result, marked by done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("transfer without a result two cycles later");

	// A result never appears without a matching earlier transfer.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching transfer");

	// A write and a pull never report in the same result.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.accepted && result.out_valid))
		else $error("result reports both a stored write and a pulled sample");

	// The end of a chunk is only marked on a pulled sample, and no sample shows without one.
	a_chunk_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.out_valid |-> !result.chunk_last && result.sample_out == '0)
		else $error("chunk end or sample data without a pulled sample");

endmodule

bind audio_fifo_low_watermark afl_checker u_afl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/audio_fifo_low_watermark_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for audio_fifo_low_watermark: directed rows, a long fill, then
// random traffic, checked by an in-bench FIFO predictor or by typed expected results.
// Depends on afl_pkg and the audio_fifo_low_watermark RTL.
module audio_fifo_low_watermark_tb;
	import afl_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0]          reg_val;
		afl_item_t            it;
		bit                   typed;
		afl_result_t          res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	afl_item_t             item = '0;
	logic                  done;
	afl_result_t           result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHUNK_FRAMES;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic                  row_typed = 1'b0;
	afl_result_t           row_exp = '0;
	bit                    idle_on = 1'b1;

	logic signed [15:0]    fifo_mem [AFL_DEPTH];
	logic [11:0]           wr_ptr = '0;
	logic [11:0]           rd_ptr = '0;
	logic [11:0]           batch_cnt = '0;
	logic                  refill_req = 1'b1;
	logic [9:0]            chunk_rem = '0;
	logic [9:0]            chunk_frames_q = CHUNK_FRAMES_RST;
	logic [11:0]           low_water_q = LOW_WATER_RST;
	logic [15:0]           volume_q = VOLUME_RST;

	afl_result_t           pending_results [$];
	dir_row_t              dir_rows [$];
	int                    err_count = 0;
	int                    quiet_cycles = 0;

	audio_fifo_low_watermark i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic logic [11:0] fill_level();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic afl_result_t predict_fifo_step(afl_item_t it);
		afl_result_t r;
		logic signed [15:0] s;
		int n;
		int g;
		int prod;
		r = '0;
		case (afl_cmd_t'(it.cmd))
		CMD_WRITE: begin
			s = (it.sample_in == MOST_NEG) ? NEG_FULL : it.sample_in;
			if (fill_level() != 12'd4095) begin
				fifo_mem[wr_ptr] = s;
				wr_ptr = wr_ptr + 12'd1;
				r.accepted = 1'b1;
				if (batch_cnt != COUNT_MAX)
					batch_cnt = batch_cnt + 12'd1;
			end
		end
		CMD_PULL: begin
			if (chunk_rem == 0) begin
				n = chunk_frames_q;
				if (n == 0)
					n = 1;
				if (n > AFL_MAX_CHUNK)
					n = AFL_MAX_CHUNK;
				if (fill_level() >= n)
					chunk_rem = 10'(n);
				else
					refill_req = 1'b1;
			end
			if (chunk_rem != 0 && fill_level() != 0) begin
				g = (volume_q > UNITY_GAIN) ? UNITY_GAIN : volume_q;
				prod = int'(fifo_mem[rd_ptr]) * g;
				r.sample_out = 16'(prod >>> 15);
				r.out_valid = 1'b1;
				rd_ptr = rd_ptr + 12'd1;
				chunk_rem = chunk_rem - 10'd1;
				if (chunk_rem == 0) begin
					r.chunk_last = 1'b1;
					if (fill_level() < low_water_q)
						refill_req = 1'b1;
				end
			end
		end
		CMD_CLEAR: begin
			refill_req = 1'b0;
		end
		default: begin
		end
		endcase
		r.written_count = batch_cnt;
		if (afl_cmd_t'(it.cmd) == CMD_WRITE && it.batch_last)
			batch_cnt = '0;
		r.needs_data = refill_req;
		r.level = fill_level();
		return r;
	endfunction

	function automatic void note_mismatch(string what, afl_result_t want, afl_result_t got);
		err_count++;
		if (err_count <= 10)
			$display("%0t %s: expected acc=%0d cnt=%0d ov=%0d smp=%0d last=%0d req=%0d lvl=%0d",
				$time, what, want.accepted, want.written_count, want.out_valid,
				want.sample_out, want.chunk_last, want.needs_data, want.level,
				"; got acc=%0d cnt=%0d ov=%0d smp=%0d last=%0d req=%0d lvl=%0d",
				got.accepted, got.written_count, got.out_valid, got.sample_out,
				got.chunk_last, got.needs_data, got.level);
	endfunction

	always @(posedge clk) begin
		afl_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected result", '0, result);
				end else begin
					want = pending_results.pop_front();
					if (result.accepted !== want.accepted
						|| result.written_count !== want.written_count
						|| result.out_valid !== want.out_valid
						|| result.sample_out !== want.sample_out
						|| result.chunk_last !== want.chunk_last
						|| result.needs_data !== want.needs_data
						|| result.level !== want.level)
						note_mismatch("result mismatch", want, result);
				end
			end
			if (start && !busy) begin
				want = predict_fifo_step(item);
				pending_results.push_back(row_typed ? row_exp : want);
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_CHUNK_FRAMES: chunk_frames_q = cfg_wdata[9:0];
				CFG_LOW_WATER: low_water_q = cfg_wdata[11:0];
				CFG_VOLUME: volume_q = cfg_wdata;
				default: begin
				end
				endcase
			end
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic afl_item_t make_item(afl_cmd_t c, logic last);
		afl_item_t it;
		it.cmd = c;
		it.batch_last = last;
		case ($urandom_range(0, 7))
		0: it.sample_in = MOST_NEG;
		1: it.sample_in = NEG_FULL;
		2: it.sample_in = 16'sh7FFF;
		3: it.sample_in = 16'sh0000;
		4: it.sample_in = -16'sd1;
		default: it.sample_in = 16'($urandom);
		endcase
		return it;
	endfunction

	function automatic afl_item_t rand_item(int write_pct);
		int r;
		afl_cmd_t c;
		r = $urandom_range(0, 99);
		if (r < write_pct)
			c = CMD_WRITE;
		else if (r < 93)
			c = CMD_PULL;
		else if (r < 97)
			c = CMD_CLEAR;
		else
			c = CMD_NOP;
		return make_item(c, $urandom_range(0, 7) == 0);
	endfunction

	function automatic dir_row_t cmd_row(afl_cmd_t c, logic signed [15:0] s, logic last);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_CHUNK_FRAMES;
		row.reg_val = '0;
		row.it.cmd = c;
		row.it.sample_in = s;
		row.it.batch_last = last;
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic dir_row_t typed_row(afl_cmd_t c, logic signed [15:0] s, logic last,
		afl_result_t r);
		dir_row_t row;
		row = cmd_row(c, s, last);
		row.typed = 1'b1;
		row.res = r;
		return row;
	endfunction

	function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		dir_row_t row;
		row = cmd_row(CMD_NOP, 16'sd0, 1'b0);
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = v;
		return row;
	endfunction

	task automatic send_item(afl_item_t it, bit typed = 1'b0, afl_result_t r = '0);
		int gap;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		row_typed <= typed;
		row_exp <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int ph;
		int i;
		int cf;
		int lw;
		int vol;
		dir_row_t row;

		// After reset: empty FIFO, refill request raised, registers at their defaults.
		dir_rows.push_back(typed_row(CMD_NOP, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd0, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd0}));
		dir_rows.push_back(typed_row(CMD_CLEAR, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 12'd0}));
		dir_rows.push_back(typed_row(CMD_PULL, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd0, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd0}));
		dir_rows.push_back(typed_row(CMD_WRITE, 16'sh7FFF, 1'b0,
			afl_result_t'{1'b1, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd1}));
		dir_rows.push_back(typed_row(CMD_WRITE, MOST_NEG, 1'b0,
			afl_result_t'{1'b1, 12'd2, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd2}));
		dir_rows.push_back(typed_row(CMD_WRITE, 16'sd0, 1'b1,
			afl_result_t'{1'b1, 12'd3, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd3}));
		dir_rows.push_back(typed_row(CMD_WRITE, 16'sh5555, 1'b0,
			afl_result_t'{1'b1, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd4}));
		dir_rows.push_back(typed_row(CMD_CLEAR, 16'sd0, 1'b1,
			afl_result_t'{1'b0, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b0, 12'd4}));
		dir_rows.push_back(typed_row(CMD_NOP, 16'sd0, 1'b1,
			afl_result_t'{1'b0, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b0, 12'd4}));
		dir_rows.push_back(typed_row(CMD_PULL, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b1, 12'd4}));
		dir_rows.push_back(reg_row(CFG_CHUNK_FRAMES, 16'd0));
		dir_rows.push_back(reg_row(CFG_LOW_WATER, 16'd0));
		dir_rows.push_back(typed_row(CMD_PULL, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd1, 1'b1, 16'sh7FFF, 1'b1, 1'b1, 12'd3}));
		dir_rows.push_back(typed_row(CMD_CLEAR, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd1, 1'b0, 16'sd0, 1'b0, 1'b0, 12'd3}));
		dir_rows.push_back(typed_row(CMD_PULL, 16'sd0, 1'b0,
			afl_result_t'{1'b0, 12'd1, 1'b1, NEG_FULL, 1'b1, 1'b0, 12'd2}));
		dir_rows.push_back(reg_row(CFG_VOLUME, 16'hFFFF));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(reg_row(CFG_VOLUME, 16'd1));
		dir_rows.push_back(cmd_row(CMD_WRITE, -16'sd1, 1'b0));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(reg_row(CFG_VOLUME, 16'd0));
		dir_rows.push_back(cmd_row(CMD_WRITE, 16'sd12345, 1'b0));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(reg_row(CFG_CHUNK_FRAMES, 16'd2));
		dir_rows.push_back(reg_row(CFG_LOW_WATER, 16'd4095));
		dir_rows.push_back(reg_row(CFG_VOLUME, 16'd32768));
		dir_rows.push_back(cmd_row(CMD_WRITE, 16'sd100, 1'b0));
		dir_rows.push_back(cmd_row(CMD_WRITE, -16'sd100, 1'b1));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));
		dir_rows.push_back(cmd_row(CMD_WRITE, 16'sd7, 1'b0));
		dir_rows.push_back(cmd_row(CMD_PULL, 16'sd0, 1'b0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				wait_drained();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.it, row.typed, row.res);
			end
		end

		// Long fill whose last write ends the batch, then pulls whose chunk size, cut to the
		// largest, is above the level: no chunk starts and each raises the refill request.
		wait_drained();
		write_reg(CFG_CHUNK_FRAMES, 16'd1023);
		write_reg(CFG_LOW_WATER, 16'd4095);
		write_reg(CFG_VOLUME, 16'd40000);
		repeat (100) send_item(make_item(CMD_WRITE, 1'b0));
		send_item(make_item(CMD_PULL, 1'b0));
		send_item(make_item(CMD_WRITE, 1'b0));
		send_item(make_item(CMD_WRITE, 1'b1));
		repeat (100) send_item(make_item(CMD_PULL, 1'b0));

		for (ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
			0: begin
				cf = 4;
				lw = 8;
				vol = 32768;
			end
			1: begin
				cf = 1;
				lw = 0;
				vol = 1;
			end
			2: begin
				cf = 0;
				lw = 4095;
				vol = 65535;
			end
			3: begin
				cf = $urandom_range(1, 16);
				lw = $urandom_range(0, 64);
				vol = $urandom_range(0, 65535);
			end
			default: begin
				cf = 2;
				lw = 3;
				vol = 16384;
			end
			endcase
			write_reg(CFG_CHUNK_FRAMES, 16'(cf));
			write_reg(CFG_LOW_WATER, 16'(lw));
			write_reg(CFG_VOLUME, 16'(vol));
			idle_on = (ph != 4);
			for (i = 0; i < 60; i++)
				send_item(rand_item((i % 40 < 20) ? 70 : 25));
		end

		wait_drained();
		repeat (4) @(negedge clk);
		err_count += pending_results.size();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
sv/afl_pkg.sv
sv/afl_core.sv
sv/afl_scale.sv
sv/audio_fifo_low_watermark.sv
sv/afl_checker.sv
sim/audio_fifo_low_watermark_tb.sv
